// ===== rtl/tce_pkg.sv =====
// ----------------------------------------------------------------------------
// tce_pkg: shared types and constants for the Takagi curve evaluator
// Formats, register indexes, and the controller/datapath command bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tce_pkg;

	// Default build parameters
	localparam int MAX_TERMS_BOUND_DEF = 50;
	localparam int FRAC_BITS_DEF       = 32;

	// Port field widths
	localparam int IN_W      = 32;
	localparam int OUT_W     = 39;
	localparam int WEIGHT_W  = 32;
	localparam int MAXT_W    = 6;
	localparam int CFG_IDX_W = 1;

	// Running weight w^k in Q1.48
	localparam int TW_FRAC = 48;
	localparam int TW_W    = TW_FRAC + 1;

	// Register reset values
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = 32'h8000_0000;
	localparam logic [MAXT_W-1:0]   MAX_TERMS_RST = 6'd50;

	// Multiplier pass sequencing: four partial products per product
	localparam int PHASE_W = 2;
	localparam logic [PHASE_W-1:0] PHASE_FIRST = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_LAST  = 2'd3;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WEIGHT    = 1'b0,
		REG_MAX_TERMS = 1'b1
	} cfg_reg_t;

	// Controller to datapath
	typedef struct packed {
		logic               load;
		logic               mul_en;
		logic [PHASE_W-1:0] phase;
		logic               step;
		logic               finish;
	} tce_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic stop;
		logic out_free;
	} tce_status_t;

endpackage

// ===== rtl/tce_mul.sv =====
// ----------------------------------------------------------------------------
// tce_mul: multi-cycle unsigned multiplier
// Splits each operand in two halves and sums the four partial products over
// four passes into a full-width product register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tce_mul #(
	parameter int A_W = 49,
	parameter int B_W = 33
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [tce_pkg::PHASE_W-1:0]       phase,
	input  logic [A_W-1:0]                    a,
	input  logic [B_W-1:0]                    b,
	output logic [A_W+B_W-1:0]                prod
);

	localparam int HA  = (A_W + 1) / 2;
	localparam int HB  = (B_W + 1) / 2;
	localparam int P_W = A_W + B_W;

	logic [HA-1:0]      a_part;
	logic [HB-1:0]      b_part;
	logic [HA+HB-1:0]   pp;
	logic [P_W-1:0]     pp_sh;
	logic [P_W-1:0]     prod_q;

	// phase[0] picks the upper half of a, phase[1] the upper half of b
	always_comb begin
		a_part = phase[0] ? HA'(a[A_W-1:HA]) : a[HA-1:0];
		b_part = phase[1] ? HB'(b[B_W-1:HB]) : b[HB-1:0];
		pp     = {{HB{1'b0}}, a_part} * {{HA{1'b0}}, b_part};
		case (phase)
			2'd0:    pp_sh = P_W'(pp);
			2'd1:    pp_sh = P_W'(pp) << HA;
			2'd2:    pp_sh = P_W'(pp) << HB;
			2'd3:    pp_sh = P_W'(pp) << (HA + HB);
			default: pp_sh = P_W'(pp);
		endcase
	end

	// Accumulate; the first pass restarts the sum
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= ((phase == tce_pkg::PHASE_FIRST) ? '0 : prod_q) + pp_sh;
		end
	end

	assign prod = prod_q;

endmodule

// ===== rtl/tce_datapath.sv =====
// ----------------------------------------------------------------------------
// tce_datapath: series datapath of the Takagi curve evaluator
// Holds the configuration, fraction, tent value, running weight, term count,
// partial sum and the output register; two multipliers form each term.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tce_datapath #(
	parameter int MAX_TERMS_BOUND = tce_pkg::MAX_TERMS_BOUND_DEF,
	parameter int FRAC_BITS       = tce_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tce_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tce_pkg::WEIGHT_W-1:0]    cfg_data,
	input  logic [tce_pkg::IN_W-1:0]        x_frac,
	input  tce_pkg::tce_cmd_t               cmd,
	output tce_pkg::tce_status_t            status,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tce_pkg::OUT_W-1:0]       curve_value
);

	localparam int FB      = FRAC_BITS;
	localparam int TENT_W  = FB + 1;
	localparam int TERM_W  = FB + 2;
	localparam int CNT_W   = $clog2(MAX_TERMS_BOUND + 1);
	localparam int ACC_W   = FB + $clog2(MAX_TERMS_BOUND) + 1;
	localparam int TW_W    = tce_pkg::TW_W;
	localparam int PT_W    = TW_W + TENT_W;
	localparam int PW_W    = TW_W + tce_pkg::WEIGHT_W;
	localparam int SC_W    = ACC_W + 32;
	localparam int OUT_W   = tce_pkg::OUT_W;
	localparam logic [TW_W-1:0] TW_ONE = {1'b1, {tce_pkg::TW_FRAC{1'b0}}};
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	// tent(t) = 2t below one half, 2(1 - t) otherwise, Q1.FB
	function automatic logic [TENT_W-1:0] tent_of(input logic [FB-1:0] t);
		logic [FB:0] diff;
		diff = {1'b1, {FB{1'b0}}} - {1'b0, t};
		if (!t[FB-1])
			tent_of = {t, 1'b0};
		else
			tent_of = {diff[FB-1:0], 1'b0};
	endfunction

	logic [tce_pkg::WEIGHT_W-1:0] weight_q;
	logic [tce_pkg::MAXT_W-1:0]   max_terms_q;
	logic [FB-1:0]                t_q;
	logic [TENT_W-1:0]            tent_q;
	logic [TW_W-1:0]              tw_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [ACC_W-1:0]             sum_q;
	logic [OUT_W-1:0]             out_q;
	logic                         out_valid_q;

	logic [FB+31:0]               x_wide;
	logic [FB-1:0]                t_in;
	logic [CNT_W-1:0]             limit;
	logic [PT_W-1:0]              prod_t;
	logic [PW_W-1:0]              prod_w;
	logic [TERM_W-1:0]            term;
	logic [TW_W-1:0]              tw_next;
	logic [FB-1:0]                t_next;
	logic [SC_W-1:0]              scaled;
	logic [OUT_W-1:0]             result;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q    <= tce_pkg::WEIGHT_RST;
			max_terms_q <= tce_pkg::MAX_TERMS_RST;
		end else if (cfg_we) begin
			case (tce_pkg::cfg_reg_t'(cfg_index))
				tce_pkg::REG_WEIGHT:    weight_q    <= cfg_data;
				tce_pkg::REG_MAX_TERMS: max_terms_q <= cfg_data[tce_pkg::MAXT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input rescale to Q0.FB and term limit clamp
	always_comb begin
		x_wide = {x_frac, {FB{1'b0}}} >> 32;
		t_in   = x_wide[FB-1:0];
		if (max_terms_q == '0)
			limit = CNT_ONE;
		else if ({1'b0, max_terms_q} > (tce_pkg::MAXT_W+1)'(MAX_TERMS_BOUND))
			limit = CNT_W'(MAX_TERMS_BOUND);
		else
			limit = CNT_W'(max_terms_q);
	end

	// Term product and weight update product
	tce_mul #(.A_W(TW_W), .B_W(TENT_W)) u_mul_term (
		.clk   (clk),
		.en    (cmd.mul_en),
		.phase (cmd.phase),
		.a     (tw_q),
		.b     (tent_q),
		.prod  (prod_t)
	);

	tce_mul #(.A_W(TW_W), .B_W(tce_pkg::WEIGHT_W)) u_mul_weight (
		.clk   (clk),
		.en    (cmd.mul_en),
		.phase (cmd.phase),
		.a     (tw_q),
		.b     (weight_q),
		.prod  (prod_w)
	);

	// Step values and stop test
	always_comb begin
		term        = prod_t[PT_W-1:tce_pkg::TW_FRAC];
		tw_next     = prod_w[32 +: TW_W];
		t_next      = {t_q[FB-2:0], 1'b0};
		status.stop = (cnt_q == CNT_ONE) || (tw_next == '0) || (t_next == '0);
		status.out_free = !out_valid_q || out_ready;
	end

	// Series state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= limit;
		end else if (cmd.step) begin
			cnt_q <= cnt_q - CNT_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q    <= t_in;
			tent_q <= tent_of(t_in);
			tw_q   <= TW_ONE;
			sum_q  <= '0;
		end else if (cmd.step) begin
			t_q    <= t_next;
			tent_q <= tent_of(t_next);
			tw_q   <= tw_next;
			sum_q  <= sum_q + ACC_W'(term);
		end
	end

	// Rescale Q.FB sum to Q7.32 with saturation
	always_comb begin
		scaled = {sum_q, 32'b0} >> FB;
		if (|scaled[SC_W-1:OUT_W])
			result = '1;
		else
			result = scaled[OUT_W-1:0];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign curve_value = out_q;

`ifndef SYNTHESIS
	// A step never runs with the term budget used up
	a_step_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (cnt_q != '0))
		else $error("term step with zero remaining count");

	// A new point starts from unit weight and an empty sum
	a_load_init: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (tw_q == TW_ONE) && (sum_q == '0))
		else $error("series not initialized on load");

	// A result is only written into a free output register
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result overwrites pending output");

	// Running weight stays in (0, 1] while products are formed
	a_tw_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_en |-> (tw_q <= TW_ONE) && (tw_q != '0))
		else $error("running weight out of range");
`endif

endmodule

// ===== rtl/tce_ctrl.sv =====
// ----------------------------------------------------------------------------
// tce_ctrl: sequencer of the Takagi curve evaluator
// Accepts a point, runs four multiplier passes and one update per term until
// the datapath reports a stop, then hands the sum to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tce_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tce_pkg::tce_status_t  status,
	output tce_pkg::tce_cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_STEP,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic [tce_pkg::PHASE_W-1:0]   phase_q;

	// Command decode
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		cmd.load   = in_ready && in_valid;
		cmd.mul_en = (state_q == ST_MUL);
		cmd.phase  = phase_q;
		cmd.step   = (state_q == ST_STEP);
		cmd.finish = (state_q == ST_DONE) && status.out_free;
	end

	// State and pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= tce_pkg::PHASE_FIRST;
		end else begin
			case (state_q)
				ST_IDLE: begin
					phase_q <= tce_pkg::PHASE_FIRST;
					if (in_valid) state_q <= ST_MUL;
				end
				ST_MUL: begin
					phase_q <= phase_q + 1'b1;
					if (phase_q == tce_pkg::PHASE_LAST) state_q <= ST_STEP;
				end
				ST_STEP: begin
					phase_q <= tce_pkg::PHASE_FIRST;
					state_q <= status.stop ? ST_DONE : ST_MUL;
				end
				ST_DONE: begin
					if (status.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/takagi_curve_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// takagi_curve_evaluator_top: generalized Takagi curve at one abscissa
// Each point sums n terms, n = terms summed (1 to 50), and each term takes four
// passes of the shared-half multipliers plus one update, until m_tvalid rises.
// One point in flight: a new point is accepted only once the last one has finished.
// A finished result waits in the output register while the next point runs.
// Reset (arst_n low, async): weight = 0.5, max_terms = 50, both channels empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module takagi_curve_evaluator_top #(
	parameter int MAX_TERMS_BOUND = tce_pkg::MAX_TERMS_BOUND_DEF,
	parameter int FRAC_BITS       = tce_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [31:0]                     s_tdata,   // [31:0] x_frac
	// output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [39:0]                     m_tdata,   // [38:0] curve_value, [39] zero
	// configuration writes
	input  logic                            cfg_we,
	input  logic [tce_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tce_pkg::WEIGHT_W-1:0]    cfg_data
);

	tce_pkg::tce_cmd_t             cmd;
	tce_pkg::tce_status_t          status;
	logic [tce_pkg::OUT_W-1:0]     curve_value;

	tce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tce_datapath #(
		.MAX_TERMS_BOUND (MAX_TERMS_BOUND),
		.FRAC_BITS       (FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.x_frac      (s_tdata),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.curve_value (curve_value)
	);

	assign m_tdata = {1'b0, curve_value};

endmodule
